### src/clut_pkg.sv
// shared types, codes and constants for the colour lookup block
`timescale 1ns / 1ps
package clut_pkg;

   // item kinds on the request channel
   localparam logic [1:0] FUNC_PIXEL = 2'd0;
   localparam logic [1:0] FUNC_TABLE = 2'd1;
   localparam logic [1:0] FUNC_SETUP = 2'd2;

   // colour table select codes
   localparam logic [1:0] SEL_BLUE  = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_RED   = 2'd2;

   // register indexes and address decode
   localparam logic REG_LINE_WIDTH = 1'b0;
   localparam logic REG_LINE_COUNT = 1'b1;
   localparam int   CSR_ADDR_W     = 3;

   // reset values and clamp limit of the span registers
   localparam logic [10:0] LINE_WIDTH_RESET = 11'd320;
   localparam logic [10:0] LINE_COUNT_RESET = 11'd240;
   localparam logic [10:0] MAX_SPAN         = 11'd1024;

   // colour table depth and decoupling queue depth (power of two)
   localparam int TABLE_DEPTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH         = 2;

   // one classified beat travelling from front to back
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] pixel_word;
      logic [1:0]  table_select;
      logic [4:0]  entry_index;
      logic [7:0]  entry_value;
      logic [31:0] background_word;
      logic        fixed_enable;
      logic        end_of_line;
      logic        end_of_frame;
   } entry_type;

endpackage

### src/clut_front.sv
// front end: accepts request beats, drops unused kinds, tracks column and row
`timescale 1ns / 1ps
module clut_front import clut_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_pixel_word,
   input  logic [1:0]  req_table_select,
   input  logic [4:0]  req_entry_index,
   input  logic [7:0]  req_entry_value,
   input  logic [31:0] req_background_word,
   input  logic        req_fixed_enable,
   input  logic [10:0] line_width,
   input  logic [10:0] line_count,
   input  logic        queue_full,
   output logic        push,
   output entry_type   entry
);

   logic [9:0] column_ff, column_in;
   logic [9:0] row_ff, row_in;
   logic [9:0] last_column, last_row;
   logic       accept, is_pixel, eol, eof;

   // register value clamped to 1..1024, minus one
   function automatic logic [9:0] span_last(input logic [10:0] reg_value);
      logic [10:0] less_one;
      less_one = reg_value - 11'd1;
      if (reg_value == 11'd0) begin
         span_last = 10'd0;
      end else if (reg_value > MAX_SPAN) begin
         span_last = 10'd1023;
      end else begin
         span_last = less_one[9:0];
      end
   endfunction

   assign req_ready   = !queue_full;
   assign accept      = req_valid && req_ready;
   assign is_pixel    = (req_func == FUNC_PIXEL);
   assign last_column = span_last(line_width);
   assign last_row    = span_last(line_count);
   assign eol         = (column_ff >= last_column);
   assign eof         = eol && (row_ff >= last_row);

   // only the three defined kinds enter the queue
   assign push = accept &&
      (req_func == FUNC_PIXEL || req_func == FUNC_TABLE || req_func == FUNC_SETUP);

   always_comb begin
      entry.kind            = req_func;
      entry.pixel_word      = req_pixel_word;
      entry.table_select    = req_table_select;
      entry.entry_index     = req_entry_index;
      entry.entry_value     = req_entry_value;
      entry.background_word = req_background_word;
      entry.fixed_enable    = req_fixed_enable;
      entry.end_of_line     = eol;
      entry.end_of_frame    = eof;
   end

   // position counters move on pixel beats only
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept && is_pixel) begin
         if (eol) begin
            column_in = 10'd0;
            row_in    = eof ? 10'd0 : row_ff + 10'd1;
         end else begin
            column_in = column_ff + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 10'd0;
         row_ff    <= 10'd0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

### src/clut_queue.sv
// short first-in first-out queue between front and back
`timescale 1ns / 1ps
module clut_queue import clut_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == COUNT_W'(0));
   assign full  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### src/clut_back.sv
// back end: colour tables, line setup and the registered result stage
`timescale 1ns / 1ps
module clut_back import clut_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_xrgb,
   output logic        rsp_end_of_line,
   output logic        rsp_end_of_frame
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [7:0]  blue_ff  [TABLE_DEPTH];
   logic [7:0]  green_ff [TABLE_DEPTH];
   logic [7:0]  red_ff   [TABLE_DEPTH];
   logic [31:0] background_ff;
   logic        fixed_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] xrgb_ff, xrgb_in;
   logic        eol_ff, eof_ff;
   logic        head_pixel, out_free;
   logic [4:0]  blue_c, green_c, red_c;
   logic [IDX_W-1:0] write_idx;

   // 5-bit field widened to 8 bits by repeating its top bits
   function automatic logic [7:0] expand5(input logic [4:0] c);
      expand5 = {c, c[4:2]};
   endfunction

   assign head_pixel = (head.kind == FUNC_PIXEL);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pop        = !empty && (!head_pixel || out_free);
   assign blue_c     = head.pixel_word[4:0];
   assign green_c    = head.pixel_word[9:5];
   assign red_c      = head.pixel_word[14:10];
   assign write_idx  = head.entry_index[IDX_W-1:0];

   // pixel conversion
   always_comb begin
      priority if (head.pixel_word == 16'd0) begin
         xrgb_in = background_ff;
      end else if (fixed_ff && head.pixel_word[15]) begin
         xrgb_in = {8'd0, expand5(red_c), expand5(green_c), expand5(blue_c)};
      end else begin
         xrgb_in = {8'd0, red_ff[red_c[IDX_W-1:0]], green_ff[green_c[IDX_W-1:0]],
                    blue_ff[blue_c[IDX_W-1:0]]};
      end
   end

   // result beat held until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop && head_pixel) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_pixel) begin
         xrgb_ff <= xrgb_in;
         eol_ff  <= head.end_of_line;
         eof_ff  <= head.end_of_frame;
      end
   end

   // table writes and line setup
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            blue_ff[i]  <= 8'd0;
            green_ff[i] <= 8'd0;
            red_ff[i]   <= 8'd0;
         end
         background_ff <= 32'd0;
         fixed_ff      <= 1'b0;
      end else if (pop) begin
         if (head.kind == FUNC_TABLE) begin
            if (head.table_select == SEL_BLUE) begin
               blue_ff[write_idx] <= head.entry_value;
            end
            if (head.table_select == SEL_GREEN) begin
               green_ff[write_idx] <= head.entry_value;
            end
            if (head.table_select == SEL_RED) begin
               red_ff[write_idx] <= head.entry_value;
            end
         end
         if (head.kind == FUNC_SETUP) begin
            background_ff <= head.background_word;
            fixed_ff      <= head.fixed_enable;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_xrgb         = xrgb_ff;
   assign rsp_end_of_line  = eol_ff;
   assign rsp_end_of_frame = eof_ff;

endmodule

### src/clut_pixel_to_xrgb_top.sv
// a pixel beat passes through the queue and then the result register before it is offered
// one beat per cycle on each side if unstalled; table and setup beats take one queue slot
// a two-entry queue parts the front from the result register; a stalled result
// blocks the input only once both queue slots are full
// reset is synchronous and active high: it clears the colour tables, background word,
// fixed flag, position counters and queue, and loads line_width 320 and line_count 240
// top level: register port, front end, queue and back end
`timescale 1ns / 1ps
module clut_pixel_to_xrgb_top import clut_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [15:0]           req_pixel_word,
   input  logic [1:0]            req_table_select,
   input  logic [4:0]            req_entry_index,
   input  logic [7:0]            req_entry_value,
   input  logic [31:0]           req_background_word,
   input  logic                  req_fixed_enable,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_xrgb,
   output logic                  rsp_end_of_line,
   output logic                  rsp_end_of_frame,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [10:0] line_width_ff;
   logic [10:0] line_count_ff;
   logic        csr_write;
   logic        reg_idx;
   logic        push, pop, empty, full;
   entry_type   push_entry, head;

   // register port
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         line_count_ff <= LINE_COUNT_RESET;
      end else if (csr_write) begin
         if (reg_idx == REG_LINE_WIDTH) begin
            line_width_ff <= csr_pwdata[10:0];
         end
         if (reg_idx == REG_LINE_COUNT) begin
            line_count_ff <= csr_pwdata[10:0];
         end
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LINE_WIDTH: csr_prdata = {21'd0, line_width_ff};
         REG_LINE_COUNT: csr_prdata = {21'd0, line_count_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   clut_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_pixel_word      (req_pixel_word),
      .req_table_select    (req_table_select),
      .req_entry_index     (req_entry_index),
      .req_entry_value     (req_entry_value),
      .req_background_word (req_background_word),
      .req_fixed_enable    (req_fixed_enable),
      .line_width          (line_width_ff),
      .line_count          (line_count_ff),
      .queue_full          (full),
      .push                (push),
      .entry               (push_entry)
   );

   clut_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   clut_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .empty            (empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_xrgb         (rsp_xrgb),
      .rsp_end_of_line  (rsp_end_of_line),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

### src/clut_checker.sv
// port-level checks on the colour lookup top level, bound to it
`timescale 1ns / 1ps
module clut_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_xrgb,
   input logic        rsp_end_of_line,
   input logic        rsp_end_of_frame,
   input logic        csr_pready
);

   // a stalled result beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_xrgb)
         && $stable(rsp_end_of_line) && $stable(rsp_end_of_frame))
      else $error("result beat changed while stalled");

   // frame end only ever falls on a line end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_end_of_line)
      else $error("end of frame without end of line");

   // no result is offered straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // register port never inserts wait states
   assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind clut_pixel_to_xrgb_top clut_checker u_clut_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_xrgb         (rsp_xrgb),
   .rsp_end_of_line  (rsp_end_of_line),
   .rsp_end_of_frame (rsp_end_of_frame),
   .csr_pready       (csr_pready)
);

### tb/sv/testbench.sv
// self-checking testbench for the rgb555 to xrgb8888 colour lookup block
`timescale 1ns / 1ps
module testbench;
   import clut_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [1:0] SEL_NONE    = 2'd3;

   localparam int SETTLE_CYCLES = 8;
   localparam int FINAL_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 200000;

   // one request beat with every field of the channel
   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] pixel;
      logic [1:0]  sel;
      logic [4:0]  idx;
      logic [7:0]  val;
      logic [31:0] bg;
      logic        fe;
   } req_beat_type;

   // one expected result beat
   typedef struct packed {
      logic [31:0] xrgb;
      logic        eol;
      logic        eof;
   } xrgb_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_func;
   logic [15:0]           req_pixel_word;
   logic [1:0]            req_table_select;
   logic [4:0]            req_entry_index;
   logic [7:0]            req_entry_value;
   logic [31:0]           req_background_word;
   logic                  req_fixed_enable;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [31:0]           rsp_xrgb;
   logic                  rsp_end_of_line;
   logic                  rsp_end_of_frame;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [7:0]  red_lut   [TABLE_DEPTH_DEFAULT];
   logic [7:0]  green_lut [TABLE_DEPTH_DEFAULT];
   logic [7:0]  blue_lut  [TABLE_DEPTH_DEFAULT];
   logic [31:0] line_bg;
   logic        fixed_on;
   logic [9:0]  column;
   logic [9:0]  row;
   logic [10:0] width_reg;
   logic [10:0] lines_reg;

   xrgb_beat_type pending_xrgb [$];
   xrgb_beat_type oldest;
   int            mismatch_count;
   int            cycle_count = 0;
   int            send_idle_pct;
   int            stall_pct;

   clut_pixel_to_xrgb_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_pixel_word      (req_pixel_word),
      .req_table_select    (req_table_select),
      .req_entry_index     (req_entry_index),
      .req_entry_value     (req_entry_value),
      .req_background_word (req_background_word),
      .req_fixed_enable    (req_fixed_enable),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_xrgb            (rsp_xrgb),
      .rsp_end_of_line     (rsp_end_of_line),
      .rsp_end_of_frame    (rsp_end_of_frame),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL clut_pixel_to_xrgb_top");
         $finish;
      end
   end

   // register value clamped to 1..1024
   function automatic int span_of(logic [10:0] r);
      if (r == 11'd0) return 1;
      if (r > MAX_SPAN) return int'(MAX_SPAN);
      return int'(r);
   endfunction

   // 5-bit channel widened to 8 bits by repeating its top bits
   function automatic logic [7:0] widen_channel(logic [4:0] c);
      return {c, c[4:2]};
   endfunction

   // apply one accepted beat to the predicted state, queueing the pixel it yields
   function void convert_beat(req_beat_type b);
      xrgb_beat_type o;
      o = '0;
      case (b.func)
         FUNC_TABLE: begin
            case (b.sel)
               SEL_BLUE:  blue_lut[b.idx] = b.val;
               SEL_GREEN: green_lut[b.idx] = b.val;
               SEL_RED:   red_lut[b.idx] = b.val;
               default:   ;
            endcase
         end
         FUNC_SETUP: begin
            line_bg  = b.bg;
            fixed_on = b.fe;
         end
         FUNC_PIXEL: begin
            if (b.pixel == 16'd0)
               o.xrgb = line_bg;
            else if (fixed_on && b.pixel[15])
               o.xrgb = {8'h00, widen_channel(b.pixel[14:10]),
                         widen_channel(b.pixel[9:5]), widen_channel(b.pixel[4:0])};
            else
               o.xrgb = {8'h00, red_lut[b.pixel[14:10]], green_lut[b.pixel[9:5]],
                         blue_lut[b.pixel[4:0]]};
            // position counters, a shrunk register ends the line at once
            if (int'(column) >= span_of(width_reg) - 1) begin
               o.eol  = 1'b1;
               column = 10'd0;
               if (int'(row) >= span_of(lines_reg) - 1) begin
                  o.eof = 1'b1;
                  row   = 10'd0;
               end else begin
                  row = row + 10'd1;
               end
            end else begin
               column = column + 10'd1;
            end
            pending_xrgb.push_back(o);
         end
         default: ;
      endcase
   endfunction

   // every field random, kind weighted towards pixels
   function automatic req_beat_type random_beat(int pix_pct);
      req_beat_type b;
      int           k;
      logic [95:0]  raw;
      raw = {$urandom, $urandom, $urandom};
      b   = raw[$bits(req_beat_type)-1:0];
      if ($urandom_range(99) < pix_pct) begin
         b.func = FUNC_PIXEL;
         k = $urandom_range(15);
         if (k == 0) b.pixel = 16'd0;
         else if (k == 1) b.pixel = 16'h8000;
      end else begin
         k = $urandom_range(7);
         b.func = (k < 5) ? FUNC_TABLE : (k < 7) ? FUNC_SETUP : FUNC_UNUSED;
      end
      return b;
   endfunction

   // present one beat, wait for its acceptance and predict it
   task push_beat(req_beat_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_func            <= b.func;
      req_pixel_word      <= b.pixel;
      req_table_select    <= b.sel;
      req_entry_index     <= b.idx;
      req_entry_value     <= b.val;
      req_background_word <= b.bg;
      req_fixed_enable    <= b.fe;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      convert_beat(b);
   endtask

   task put_pixel(logic [15:0] pix);
      req_beat_type b;
      b       = random_beat(0);
      b.func  = FUNC_PIXEL;
      b.pixel = pix;
      push_beat(b);
   endtask

   task put_entry(logic [1:0] sel, logic [4:0] idx, logic [7:0] val);
      req_beat_type b;
      b      = random_beat(0);
      b.func = FUNC_TABLE;
      b.sel  = sel;
      b.idx  = idx;
      b.val  = val;
      push_beat(b);
   endtask

   task put_setup(logic [31:0] bg, logic fe);
      req_beat_type b;
      b      = random_beat(0);
      b.func = FUNC_SETUP;
      b.bg   = bg;
      b.fe   = fe;
      push_beat(b);
   endtask

   // hold the sender until every expected pixel is out, then settle
   task wait_for_xrgb_drain(int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_xrgb.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // register write followed by a read back, upper data bits random
   task write_span_reg(logic reg_idx, logic [10:0] value);
      logic [31:0] data;
      data        = $urandom;
      data[10:0]  = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {21'd0, value}) begin
         mismatch_count++;
         $display("%0t: register %0d read expected %08h actual %08h",
                  $time, reg_idx, {21'd0, value}, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (reg_idx == REG_LINE_WIDTH) width_reg = value;
      else lines_reg = value;
   endtask

   // one random phase under one register setting and one idling pattern
   task run_phase(logic [10:0] wid, logic [10:0] lines, int sidle, int stall,
                  int beats, int pix_pct, bit hold_midway);
      wait_for_xrgb_drain(SETTLE_CYCLES);
      write_span_reg(REG_LINE_WIDTH, wid);
      write_span_reg(REG_LINE_COUNT, lines);
      send_idle_pct = sidle;
      stall_pct     = stall;
      for (int n = 0; n < beats; n++) begin
         if (hold_midway && n == beats / 2) wait_for_xrgb_drain(0);
         push_beat(random_beat(pix_pct));
      end
   endtask

   // table writes, background pass-through, fixed expansion and ignored kinds
   task test_lookup_paths();
      req_beat_type b;
      send_idle_pct = 0;
      stall_pct     = 0;
      put_entry(SEL_BLUE, 5'd31, 8'hA5);
      put_entry(SEL_GREEN, 5'd31, 8'h3C);
      put_entry(SEL_RED, 5'd31, 8'hFF);
      put_entry(SEL_GREEN, 5'd0, 8'h80);
      put_entry(SEL_RED, 5'd1, 8'h5A);
      put_entry(SEL_NONE, 5'd5, 8'h77);
      put_pixel(16'h0000);
      put_pixel(16'h7FFF);
      put_pixel(16'hFFFF);
      put_pixel(16'h0005);
      put_setup(32'hFFFF_FFFF, 1'b1);
      put_pixel(16'h0000);
      put_pixel(16'hFFFF);
      put_pixel(16'h8000);
      put_pixel(16'h7FFF);
      put_pixel(16'h8421);
      b      = random_beat(0);
      b.func = FUNC_UNUSED;
      push_beat(b);
      put_setup(32'h0000_0000, 1'b0);
      put_pixel(16'h0000);
      put_pixel(16'h8421);
      put_setup(32'h5A5A_A5A5, 1'b1);
      put_pixel(16'h0000);
   endtask

   // widths that clamp to 1024, with runs too short to finish a full line
   task test_long_lines();
      run_phase(11'd2047, 11'd0,    0,  0,  256, 100, 1'b0);
      run_phase(11'd1024, 11'd3,    64, 0,  256, 100, 1'b1);
      run_phase(11'd1500, 11'd1024, 0,  64, 256, 100, 1'b0);
      run_phase(11'd1200, 11'd2047, 11, 11, 256, 100, 1'b0);
   endtask

   // tiny frames: shrink in mid-line, zero registers, frequent frame ends
   task test_short_frames();
      run_phase(11'd3, 11'd2, 0,  0,  15, 80, 1'b0);
      run_phase(11'd0, 11'd0, 64, 0,  15, 80, 1'b0);
      run_phase(11'd1, 11'd4, 0,  64, 15, 80, 1'b0);
      run_phase(11'd5, 11'd3, 11, 11, 15, 80, 1'b0);
      run_phase(11'($urandom_range(9, 2)), 11'($urandom_range(4, 1)), 0, 0, 15, 80, 1'b0);
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_xrgb.size() == 0) begin
            mismatch_count++;
            $display("%0t: result beat expected none actual xrgb %08h", $time, rsp_xrgb);
         end else begin
            oldest = pending_xrgb.pop_front();
            if (rsp_xrgb !== oldest.xrgb) begin
               mismatch_count++;
               $display("%0t: xrgb expected %08h actual %08h", $time, oldest.xrgb, rsp_xrgb);
            end
            if (rsp_end_of_line !== oldest.eol) begin
               mismatch_count++;
               $display("%0t: end_of_line expected %0b actual %0b",
                        $time, oldest.eol, rsp_end_of_line);
            end
            if (rsp_end_of_frame !== oldest.eof) begin
               mismatch_count++;
               $display("%0t: end_of_frame expected %0b actual %0b",
                        $time, oldest.eof, rsp_end_of_frame);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // test sequence
   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_func            <= FUNC_PIXEL;
      req_pixel_word      <= '0;
      req_table_select    <= SEL_BLUE;
      req_entry_index     <= '0;
      req_entry_value     <= '0;
      req_background_word <= '0;
      req_fixed_enable    <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      mismatch_count      = 0;
      send_idle_pct       = 0;
      stall_pct           = 0;
      for (int i = 0; i < TABLE_DEPTH_DEFAULT; i++) begin
         red_lut[i]   = 8'h00;
         green_lut[i] = 8'h00;
         blue_lut[i]  = 8'h00;
      end
      line_bg   = 32'd0;
      fixed_on  = 1'b0;
      column    = 10'd0;
      row       = 10'd0;
      width_reg = LINE_WIDTH_RESET;
      lines_reg = LINE_COUNT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_lookup_paths();
      test_long_lines();
      test_short_frames();

      wait_for_xrgb_drain(FINAL_CYCLES);
      if (mismatch_count == 0)
         $display("PASS clut_pixel_to_xrgb_top");
      else
         $display("FAIL clut_pixel_to_xrgb_top");
      $finish;
   end

endmodule
